@@ hdl/b64e_pkg.sv @@
// Shared types, constants and the alphabet mapping for the base64 line encoder.
`timescale 1ns / 1ps
package b64e_pkg;

  localparam int MAX_CHARS   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [6:0] LINE_LIMIT = 7'd76;
  localparam logic [6:0] GROUP_LEN  = 7'd4;
  localparam logic [6:0] CHAR_CR    = 7'd13;
  localparam logic [6:0] CHAR_LF    = 7'd10;
  localparam logic [6:0] CHAR_PAD   = 7'd61;

  localparam logic [2:0] CNT_GROUP  = 3'd4;
  localparam logic [2:0] CNT_BREAK  = 3'd6;

  // One burst of characters produced by a single input byte.
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [2:0]                count;
    logic                      last;
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [6:0] b64_sym(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd26)       return w + 7'd65;
    else if (v < 6'd52)  return w + 7'd71;
    else if (v < 6'd62)  return w - 7'd4;
    else if (v == 6'd62) return 7'd43;
    else                 return 7'd47;
  endfunction

endpackage

@@ hdl/b64e_byte_if.sv @@
// Byte input channel: valid/ready with one raw byte and its end flag.
`timescale 1ns / 1ps
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

@@ hdl/b64e_char_if.sv @@
// Character output channel: valid/ready with one ASCII code and its end flag.
`timescale 1ns / 1ps
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

@@ hdl/b64e_front.sv @@
// Front end: accepts bytes, tracks group and line state, builds character bursts.
`timescale 1ns / 1ps
module b64e_front (
  input  logic           clk,
  input  logic           rst,
  b64e_byte_if.sink      bytes,
  input  logic           full,
  output logic           push,
  output b64e_pkg::job_t job
);
  import b64e_pkg::*;

  logic [15:0] pending;
  logic [1:0]  phase;
  logic [6:0]  line_chars;

  logic [15:0] pending_next;
  logic [1:0]  phase_next;
  logic [6:0]  line_chars_next;

  logic [7:0]  first;
  logic [7:0]  second;
  logic [7:0]  b;
  logic        eom;
  logic        accept;
  logic [6:0]  line_sum;
  logic        brk;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;
  assign first       = pending[15:8];
  assign second      = pending[7:0];
  assign b           = bytes.data_byte;
  assign eom         = bytes.end_of_message;
  assign line_sum    = line_chars + GROUP_LEN;
  assign brk         = line_sum >= LINE_LIMIT;

  always_comb begin
    job             = '0;
    job.last        = eom;
    job.count       = CNT_GROUP;
    push            = 1'b0;
    pending_next    = pending;
    phase_next      = phase;
    line_chars_next = line_chars;
    case (phase)
      2'd2: begin
        push          = accept;
        job.chars[0]  = b64_sym(first[7:2]);
        job.chars[1]  = b64_sym({first[1:0], second[7:4]});
        job.chars[2]  = b64_sym({second[3:0], b[7:6]});
        job.chars[3]  = b64_sym(b[5:0]);
        job.chars[4]  = CHAR_CR;
        job.chars[5]  = CHAR_LF;
        job.count     = brk ? CNT_BREAK : CNT_GROUP;
        pending_next  = '0;
        phase_next    = 2'd0;
        line_chars_next = brk ? 7'd0 : line_sum;
      end
      2'd1: begin
        push          = accept && eom;
        job.chars[0]  = b64_sym(first[7:2]);
        job.chars[1]  = b64_sym({first[1:0], b[7:4]});
        job.chars[2]  = b64_sym({b[3:0], 2'b00});
        job.chars[3]  = CHAR_PAD;
        pending_next  = {first, b};
        phase_next    = 2'd2;
      end
      default: begin
        // phase 3 never arises; handled like an empty group
        push          = accept && eom;
        job.chars[0]  = b64_sym(b[7:2]);
        job.chars[1]  = b64_sym({b[1:0], 4'b0000});
        job.chars[2]  = CHAR_PAD;
        job.chars[3]  = CHAR_PAD;
        pending_next  = {b, 8'h00};
        phase_next    = 2'd1;
      end
    endcase
    if (eom) begin
      pending_next    = '0;
      phase_next      = 2'd0;
      line_chars_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      phase      <= '0;
      line_chars <= '0;
    end else if (accept) begin
      pending    <= pending_next;
      phase      <= phase_next;
      line_chars <= line_chars_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst) phase != 2'd3)
    else $error("group phase left its range");
  a_line_range: assert property (@(posedge clk) disable iff (rst) line_chars < LINE_LIMIT)
    else $error("line count reached the limit without a break");
  a_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("burst pushed into a full queue");

endmodule

@@ hdl/b64e_queue.sv @@
// Two-entry queue of character bursts between front and back ends.
`timescale 1ns / 1ps
module b64e_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::job_t wr_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output b64e_pkg::job_t head
);
  import b64e_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full      = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ hdl/b64e_back.sv @@
// Back end: walks the head burst one character per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           not_empty,
  input  b64e_pkg::job_t head,
  output logic           pop,
  b64e_char_if.source    chars
);
  import b64e_pkg::*;

  logic [2:0] idx;
  logic       out_valid;
  logic [6:0] out_char;
  logic       out_last;
  logic       load;
  logic       at_end;

  assign load   = not_empty && (!out_valid || chars.ready);
  assign at_end = idx == head.count - 3'd1;
  assign pop    = load && at_end;

  assign chars.valid     = out_valid;
  assign chars.out_char  = out_char;
  assign chars.last_char = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_end ? 3'd0 : idx + 3'd1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head.chars[idx];
      out_last <= head.last && at_end;
    end
  end

  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
      not_empty |-> idx < head.count)
    else $error("character index past end of burst");
  a_burst_len: assert property (@(posedge clk) disable iff (rst)
      not_empty |-> (head.count == CNT_GROUP || head.count == CNT_BREAK))
    else $error("burst length is neither a group nor a group with a break");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
      !not_empty |-> idx == 3'd0)
    else $error("index not rewound while the queue is empty");

endmodule

@@ hdl/base64_line_wrapped_encoder.sv @@
// Top level of the base64 encoder with CR LF every 76 characters.
// Bytes enter on the bytes channel and the encoded ASCII stream leaves on the chars channel,
// one character per transaction; last_char flags the final character of a message. A byte is
// taken in the cycle it is offered whenever the two-entry burst queue has room, so bytes that
// only fill a group go through back to back. A byte that completes a group (or ends the
// message) queues a burst of 4 characters, or 6 with a line break, and the output register
// drains one character per cycle while chars.ready is high, so the sustained pace is set by
// that single character port. The first character of a burst is written into the queue and
// then into the output register on its way to the chars port.
`timescale 1ns / 1ps
module base64_line_wrapped_encoder (
  input  logic        clk,
  input  logic        rst,
  b64e_byte_if.sink   bytes,
  b64e_char_if.source chars
);
  import b64e_pkg::*;

  logic full;
  logic push;
  logic pop;
  logic not_empty;
  job_t wr_job;
  job_t head;

  b64e_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .job   (wr_job)
  );

  b64e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (wr_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .chars     (chars)
  );

endmodule
